/* sv/lkr_pkg.sv */
// Shared types and constants for the LRU-K frame replacer.
// Holds the transaction payload structs, operation codes, control state
// encoding and configuration register map. No dependencies.
package lkr_pkg;

   // Number of frames; the frame fields of both payloads are sized for it.
   localparam int FRAME_COUNT = 64;

   typedef enum logic [1:0] {
      OP_ACCESS        = 2'd0,
      OP_SET_EVICTABLE = 2'd1,
      OP_REMOVE        = 2'd2,
      OP_EVICT         = 2'd3
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [5:0] frame_index;
      logic       evictable_value;
   } req_type;

   typedef struct packed {
      logic       evict_ok;
      logic [5:0] victim_frame;
      logic       status;
      logic [6:0] evictable_count;
   } rsp_type;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   // Configuration port: one 32-bit register per word.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_HISTORY_DEPTH = 1'b0;

   localparam int HIST_DEPTH_W = 4;
   localparam logic [HIST_DEPTH_W-1:0] HIST_DEPTH_RESET = 4'd2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_APPLY  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_PICK   = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   // Classification of one frame as it leaves the scan read stage.
   typedef struct packed {
      logic valid;
      logic partial;
      logic full;
   } scan_tag_type;

endpackage

/* sv/lkr_hist_ram.sv */
// Timestamp history memory: one write port, one registered read port.
// No package dependencies.
module lkr_hist_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lkr_meta_store.sv */
// Per-frame metadata memory (count, write slot, mark) with a valid bit per
// entry; an invalid entry reads as all zero. No package dependencies.
module lkr_meta_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic          clr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0]    mem [DEPTH];
   logic [DW-1:0]    rd_q_ff;
   logic [DEPTH-1:0] valid_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (clr_en) begin
            valid_ff[wr_addr] <= 1'b0;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

/* sv/lkr_victim_select.sv */
// Running minimum over scanned frames, one tracker for frames with fewer
// than K accesses and one for full frames. Uses lkr_pkg::scan_tag_type.
module lkr_victim_select #(
   parameter int IW = 6,
   parameter int TW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  lkr_pkg::scan_tag_type tag,
   input  logic [IW-1:0]        tag_index,
   input  logic [TW-1:0]        stamp,
   output logic                 found,
   output logic [IW-1:0]        victim
);

   logic          p_found_ff, p_found_in;
   logic [TW-1:0] p_best_ff, p_best_in;
   logic [IW-1:0] p_idx_ff, p_idx_in;
   logic          f_found_ff, f_found_in;
   logic [TW-1:0] f_best_ff, f_best_in;
   logic [IW-1:0] f_idx_ff, f_idx_in;

   // Strict compare: scan runs upward, so the lowest index keeps a tie.
   always_comb begin
      p_found_in = p_found_ff;
      p_best_in  = p_best_ff;
      p_idx_in   = p_idx_ff;
      f_found_in = f_found_ff;
      f_best_in  = f_best_ff;
      f_idx_in   = f_idx_ff;
      if (clear) begin
         p_found_in = 1'b0;
         f_found_in = 1'b0;
      end else if (tag.valid) begin
         if (tag.partial && (!p_found_ff || stamp < p_best_ff)) begin
            p_found_in = 1'b1;
            p_best_in  = stamp;
            p_idx_in   = tag_index;
         end
         if (tag.full && (!f_found_ff || stamp < f_best_ff)) begin
            f_found_in = 1'b1;
            f_best_in  = stamp;
            f_idx_in   = tag_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_found_ff <= 1'b0;
         f_found_ff <= 1'b0;
      end else begin
         p_found_ff <= p_found_in;
         f_found_ff <= f_found_in;
      end
      p_best_ff <= p_best_in;
      p_idx_ff  <= p_idx_in;
      f_best_ff <= f_best_in;
      f_idx_ff  <= f_idx_in;
   end

   assign found  = p_found_ff || f_found_ff;
   assign victim = p_found_ff ? p_idx_ff : f_idx_ff;

endmodule

/* sv/lru_k_frame_replacer.sv */
// LRU-K frame replacer top level: control sequencer, config register,
// result register. Depends on lkr_pkg, lkr_meta_store, lkr_hist_ram and
// lkr_victim_select.
//
// Usage:
//   req_valid/req_stall/req_payload carry one operation per transaction
//   (access, set evictable mark, remove, evict). rsp_valid/rsp_stall/
//   rsp_payload return exactly one result per request, in order.
//   The APB-style port writes history_depth (K) at word 0; write it only
//   while no request is outstanding.
// Timing:
//   Access, mark and remove read the frame's metadata, apply the change and
//   post the result through the APPLY and RESULT states, taking no new request
//   meanwhile. Evict sweeps all frames through a metadata read and a history
//   read, one frame a cycle, then picks the victim. The next request is
//   taken once the block returns to idle, even while the last result stalls.
// Reset: synchronous, clears all frame metadata (valid bits), the access
//   clock, the evictable total and sets K to 2. History stamps are not
//   cleared; they are only used once written.
// Stall: a stalled result holds in the output register; a finished
//   operation waits for the register to free before posting its result.
module lru_k_frame_replacer #(
   parameter int MAX_HISTORY = 8,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lkr_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lkr_pkg::rsp_type               rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lkr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lkr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lkr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int FW   = $clog2(lkr_pkg::FRAME_COUNT);
   localparam int SW   = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int CW   = $clog2(MAX_HISTORY + 1);
   localparam int HAW  = (lkr_pkg::FRAME_COUNT * MAX_HISTORY > 1) ?
                         $clog2(lkr_pkg::FRAME_COUNT * MAX_HISTORY) : 1;
   localparam int TOTW = $clog2(lkr_pkg::FRAME_COUNT + 1);
   localparam int MW   = CW + SW + 1;
   localparam logic [HAW-1:0]        HIST_STRIDE = HAW'(MAX_HISTORY);
   localparam logic [TIME_WIDTH-1:0] TIME_MAX    = {TIME_WIDTH{1'b1}};

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   lkr_pkg::state_type state_ff, state_in;
   lkr_pkg::op_type    op_ff, op_in;
   logic [FW-1:0]      frame_ff, frame_in;
   logic               ev_ff, ev_in;
   logic               in_range_ff, in_range_in;
   logic [lkr_pkg::HIST_DEPTH_W-1:0] k_ff, k_in;
   logic [TIME_WIDTH-1:0] clock_ff, clock_in;
   logic [TOTW-1:0]    total_ff, total_in;
   logic [TOTW-1:0]    scan_cnt_ff, scan_cnt_in;
   logic               s1_v_ff, s1_v_in;
   logic [FW-1:0]      s1_idx_ff, s1_idx_in;
   lkr_pkg::scan_tag_type s2_tag_ff, s2_tag_in;
   logic [FW-1:0]      s2_idx_ff, s2_idx_in;
   lkr_pkg::rsp_type   pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lkr_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic rsp_load;
   logic csr_write;
   logic [lkr_pkg::CSR_INDEX_W-1:0] csr_index;

   // Memory ports
   logic [FW-1:0]         meta_raddr;
   logic [MW-1:0]         meta_rdata;
   logic                  meta_wr_en;
   logic                  meta_clr_en;
   logic [FW-1:0]         meta_waddr;
   logic [MW-1:0]         meta_wdata;
   logic                  hist_wr_en;
   logic [HAW-1:0]        hist_waddr;
   logic [HAW-1:0]        hist_raddr;
   logic [TIME_WIDTH-1:0] hist_rdata;

   logic                  sel_clear;
   logic                  sel_found;
   logic [FW-1:0]         sel_victim;

   // Decoded metadata
   logic [CW-1:0] md_count;
   logic [SW-1:0] md_slot;
   logic          md_mark;
   logic [CW-1:0] k_eff;
   logic [CW-1:0] back_n;
   logic [CW:0]   back_sum;
   logic [SW-1:0] back_slot;
   logic [SW-1:0] next_slot;
   logic [CW-1:0] next_count;
   logic          has_hist;

   assign {md_count, md_slot, md_mark} = meta_rdata;
   assign has_hist = (md_count != '0);

   // Clamp K to 1..MAX_HISTORY.
   always_comb begin
      if (k_ff == '0) begin
         k_eff = CW'(1);
      end else if (32'(k_ff) > MAX_HISTORY) begin
         k_eff = CW'(MAX_HISTORY);
      end else begin
         k_eff = CW'(k_ff);
      end
   end

   // Ring slot holding the stamp n accesses back.
   always_comb begin
      back_n = (has_hist && md_count < k_eff) ? md_count : k_eff;
      back_sum = (CW+1)'(md_slot) + (CW+1)'(MAX_HISTORY) - (CW+1)'(back_n);
      if (32'(back_sum) >= MAX_HISTORY) begin
         back_sum = back_sum - (CW+1)'(MAX_HISTORY);
      end
      back_slot = SW'(back_sum);
   end

   always_comb begin
      if (32'(md_slot) == MAX_HISTORY - 1) begin
         next_slot = '0;
      end else begin
         next_slot = md_slot + SW'(1);
      end
      next_count = (md_count < k_eff) ? md_count + CW'(1) : md_count;
   end

   // ---------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------
   assign req_stall  = (state_ff != lkr_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == lkr_pkg::ST_RESULT) && (!rsp_valid_ff || !rsp_stall);
   assign sel_clear  = req_accept && (req_payload.operation == lkr_pkg::OP_EVICT);

   // Configuration port
   assign pready    = 1'b1;
   assign csr_index = paddr[lkr_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (csr_index == lkr_pkg::REG_HISTORY_DEPTH) ?
                      lkr_pkg::CSR_DATA_W'(k_ff) : '0;

   always_comb begin
      k_in = k_ff;
      if (csr_write && csr_index == lkr_pkg::REG_HISTORY_DEPTH) begin
         k_in = pwdata[lkr_pkg::HIST_DEPTH_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      frame_in    = frame_ff;
      ev_in       = ev_ff;
      in_range_in = in_range_ff;
      clock_in    = clock_ff;
      total_in    = total_ff;
      scan_cnt_in = scan_cnt_ff;
      s1_v_in     = 1'b0;
      s1_idx_in   = s1_idx_ff;
      pend_in     = pend_ff;
      meta_raddr  = FW'(req_payload.frame_index);
      meta_wr_en  = 1'b0;
      meta_clr_en = 1'b0;
      meta_waddr  = frame_ff;
      meta_wdata  = {md_count, md_slot, md_mark};
      hist_wr_en  = 1'b0;
      hist_waddr  = HAW'(frame_ff) * HIST_STRIDE + HAW'(md_slot);

      case (state_ff)
         lkr_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in       = req_payload.operation;
               frame_in    = FW'(req_payload.frame_index);
               ev_in       = req_payload.evictable_value;
               in_range_in = (32'(req_payload.frame_index) < lkr_pkg::FRAME_COUNT);
               scan_cnt_in = '0;
               state_in    = (req_payload.operation == lkr_pkg::OP_EVICT) ?
                             lkr_pkg::ST_SCAN : lkr_pkg::ST_APPLY;
            end
         end

         lkr_pkg::ST_APPLY: begin
            pend_in.evict_ok     = 1'b0;
            pend_in.victim_frame = '0;
            pend_in.status       = lkr_pkg::STATUS_DONE;
            case (op_ff)
               lkr_pkg::OP_ACCESS: begin
                  if (in_range_ff) begin
                     hist_wr_en = 1'b1;
                     meta_wr_en = 1'b1;
                     meta_wdata = {next_count, next_slot, md_mark};
                     if (clock_ff != TIME_MAX) begin
                        clock_in = clock_ff + TIME_WIDTH'(1);
                     end
                  end
               end
               lkr_pkg::OP_SET_EVICTABLE: begin
                  if (in_range_ff && has_hist && (md_mark != ev_ff)) begin
                     meta_wr_en = 1'b1;
                     meta_wdata = {md_count, md_slot, ev_ff};
                     total_in   = ev_ff ? total_ff + TOTW'(1) : total_ff - TOTW'(1);
                  end
               end
               lkr_pkg::OP_REMOVE: begin
                  if (in_range_ff && has_hist) begin
                     if (md_mark) begin
                        meta_clr_en = 1'b1;
                        total_in    = total_ff - TOTW'(1);
                     end else begin
                        pend_in.status = lkr_pkg::STATUS_REFUSED;
                     end
                  end
               end
               default: begin
               end
            endcase
            pend_in.evictable_count = 7'(total_in);
            state_in = lkr_pkg::ST_RESULT;
         end

         lkr_pkg::ST_SCAN: begin
            // Issue one metadata read a cycle; drain the two read stages.
            meta_raddr = FW'(scan_cnt_ff);
            if (32'(scan_cnt_ff) < lkr_pkg::FRAME_COUNT) begin
               s1_v_in     = 1'b1;
               s1_idx_in   = FW'(scan_cnt_ff);
               scan_cnt_in = scan_cnt_ff + TOTW'(1);
            end else if (!s1_v_ff && !s2_tag_ff.valid) begin
               state_in = lkr_pkg::ST_PICK;
            end
         end

         lkr_pkg::ST_PICK: begin
            meta_waddr              = sel_victim;
            pend_in.evict_ok        = sel_found;
            pend_in.victim_frame    = sel_found ? 6'(sel_victim) : '0;
            pend_in.status          = lkr_pkg::STATUS_DONE;
            if (sel_found) begin
               meta_clr_en = 1'b1;
               total_in    = total_ff - TOTW'(1);
            end
            pend_in.evictable_count = 7'(total_in);
            state_in = lkr_pkg::ST_RESULT;
         end

         lkr_pkg::ST_RESULT: begin
            if (rsp_load) begin
               state_in = lkr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lkr_pkg::ST_IDLE;
         end
      endcase
   end

   // Scan read stage: classify the frame and fetch its ranking stamp.
   always_comb begin
      s2_tag_in.valid   = s1_v_ff;
      s2_tag_in.partial = s1_v_ff && md_mark && has_hist && (md_count < k_eff);
      s2_tag_in.full    = s1_v_ff && md_mark && (md_count >= k_eff);
      s2_idx_in         = s1_idx_ff;
      hist_raddr        = HAW'(s1_idx_ff) * HIST_STRIDE + HAW'(back_slot);
   end

   // Output register: hold while stalled, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkr_pkg::ST_IDLE;
         k_ff         <= lkr_pkg::HIST_DEPTH_RESET;
         clock_ff     <= '0;
         total_ff     <= '0;
         scan_cnt_ff  <= '0;
         s1_v_ff      <= 1'b0;
         s2_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         in_range_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         clock_ff     <= clock_in;
         total_ff     <= total_in;
         scan_cnt_ff  <= scan_cnt_in;
         s1_v_ff      <= s1_v_in;
         s2_tag_ff    <= s2_tag_in;
         rsp_valid_ff <= rsp_valid_in;
         in_range_ff  <= in_range_in;
      end
      op_ff       <= op_in;
      frame_ff    <= frame_in;
      ev_ff       <= ev_in;
      s1_idx_ff   <= s1_idx_in;
      s2_idx_ff   <= s2_idx_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ---------------------------------------------------------------
   // Storage and selection
   // ---------------------------------------------------------------
   lkr_meta_store #(
      .DEPTH (lkr_pkg::FRAME_COUNT),
      .AW    (FW),
      .DW    (MW)
   ) u_meta (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata),
      .wr_en   (meta_wr_en),
      .clr_en  (meta_clr_en),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata)
   );

   lkr_hist_ram #(
      .DEPTH (lkr_pkg::FRAME_COUNT * MAX_HISTORY),
      .AW    (HAW),
      .DW    (TIME_WIDTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_waddr),
      .wr_data (clock_ff),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   lkr_victim_select #(
      .IW (FW),
      .TW (TIME_WIDTH)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .clear     (sel_clear),
      .tag       (s2_tag_ff),
      .tag_index (s2_idx_ff),
      .stamp     (hist_rdata),
      .found     (sel_found),
      .victim    (sel_victim)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_evict_enters_scan: assert property (@(posedge clock) disable iff (reset)
      sel_clear |=> (state_ff == lkr_pkg::ST_SCAN))
      else $error("evict request did not start a scan");

   a_evict_drops_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lkr_pkg::ST_PICK && sel_found) |=>
      (total_ff == $past(total_ff) - TOTW'(1)))
      else $error("eviction did not decrement the evictable total");

   a_clock_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lkr_pkg::ST_APPLY && op_ff == lkr_pkg::OP_ACCESS && in_range_ff
       && clock_ff != TIME_MAX) |=> (clock_ff == $past(clock_ff) + TIME_WIDTH'(1)))
      else $error("access clock did not advance on an access");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (32'(total_ff) <= lkr_pkg::FRAME_COUNT))
      else $error("evictable total exceeds frame count");

endmodule

/* sim/lru_k_frame_replacer_tb.sv */
// Self-checking testbench for lru_k_frame_replacer: directed table, then random
// operation streams under several K settings and idle patterns.
// Depends on lkr_pkg and the lru_k_frame_replacer RTL.
module lru_k_frame_replacer_tb;

   localparam int FRAMES     = lkr_pkg::FRAME_COUNT;
   localparam int HIST_SLOTS = 8;
   localparam int CYCLE_CAP  = 1000000;
   localparam int PHASE_OPS  = 115;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   lkr_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   lkr_pkg::rsp_type               rsp_payload;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [lkr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [lkr_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [lkr_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   lru_k_frame_replacer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Clock: period 20.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the replacer state.
   logic [31:0] stamp_ring [FRAMES][HIST_SLOTS];
   logic [3:0]  use_count  [FRAMES];
   logic [2:0]  ring_head  [FRAMES];
   logic        evict_mark [FRAMES];
   logic [6:0]  mark_total;
   logic [31:0] stamp_clock;
   logic [3:0]  depth_reg;

   lkr_pkg::rsp_type pending_rsps [$];
   int      error_count = 0;
   int      rsp_seen = 0;
   int      evict_hits = 0;
   int      refusals = 0;
   int      cycle_count = 0;
   int      sender_idle_pct = 0;
   int      receiver_idle_pct = 0;

   typedef struct {
      lkr_pkg::req_type op;
      bit               fixed;
      lkr_pkg::rsp_type want;
   } table_row;

   table_row directed [$];

   function automatic int depth_used();
      if (depth_reg == 0) return 1;
      if (depth_reg > HIST_SLOTS) return HIST_SLOTS;
      return int'(depth_reg);
   endfunction

   function automatic logic [31:0] stamp_ago(int f, int n);
      return stamp_ring[f][(ring_head[f] + HIST_SLOTS - n) % HIST_SLOTS];
   endfunction

   function automatic void wipe_frame(int f);
      use_count[f] = 0;
      ring_head[f] = 0;
      if (evict_mark[f]) begin
         evict_mark[f] = 1'b0;
         mark_total--;
      end
   endfunction

   // Apply one operation to the shadow state and return its result.
   function automatic lkr_pkg::rsp_type replace_step(lkr_pkg::req_type r);
      lkr_pkg::rsp_type res;
      int          f;
      int          k;
      int          pick;
      bit          found;
      logic [31:0] oldest;
      logic [31:0] t;
      res = '0;
      f = int'(r.frame_index);
      k = depth_used();
      found = 0;
      pick = 0;
      oldest = '0;
      case (r.operation)
         lkr_pkg::OP_ACCESS: begin
            stamp_ring[f][ring_head[f]] = stamp_clock;
            ring_head[f] = ring_head[f] + 3'd1;
            if (use_count[f] < k) use_count[f]++;
            if (stamp_clock != 32'hFFFF_FFFF) stamp_clock++;
         end
         lkr_pkg::OP_SET_EVICTABLE: begin
            if (use_count[f] != 0) begin
               if (!evict_mark[f] && r.evictable_value) begin
                  evict_mark[f] = 1'b1;
                  mark_total++;
               end else if (evict_mark[f] && !r.evictable_value) begin
                  evict_mark[f] = 1'b0;
                  mark_total--;
               end
            end
         end
         lkr_pkg::OP_REMOVE: begin
            if (use_count[f] != 0) begin
               if (evict_mark[f]) wipe_frame(f);
               else res.status = lkr_pkg::STATUS_REFUSED;
            end
         end
         default: begin
            // Frames short of K history go first, ranked by oldest retained stamp.
            for (int i = 0; i < FRAMES; i++) begin
               if (!evict_mark[i] || use_count[i] == 0 || use_count[i] >= k) continue;
               t = stamp_ago(i, int'(use_count[i]));
               if (!found || t < oldest) begin
                  found = 1; oldest = t; pick = i;
               end
            end
            // Otherwise rank full frames by their K-th most recent stamp.
            if (!found) begin
               for (int i = 0; i < FRAMES; i++) begin
                  if (!evict_mark[i] || use_count[i] < k) continue;
                  t = stamp_ago(i, k);
                  if (!found || t < oldest) begin
                     found = 1; oldest = t; pick = i;
                  end
               end
            end
            if (found) begin
               wipe_frame(pick);
               res.evict_ok = 1'b1;
               res.victim_frame = pick[5:0];
            end
         end
      endcase
      res.evictable_count = mark_total;
      return res;
   endfunction

   // Issue one transaction; hold valid and payload until it is taken.
   task automatic issue(lkr_pkg::req_type r, bit fixed, lkr_pkg::rsp_type want);
      lkr_pkg::rsp_type predicted;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = replace_step(r);
      pending_rsps = {pending_rsps, (fixed ? want : predicted)};
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
   endtask

   // Write history_depth through the register port while the block is idle.
   task automatic write_depth(logic [3:0] value);
      drain();
      repeat (8) @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {28'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      depth_reg = value;
   endtask

   function automatic table_row row(lkr_pkg::op_type op, int f, bit ev, bit fixed = 0,
                                    bit ok = 0, int v = 0, bit st = 0, int cnt = 0);
      table_row t;
      t.op = '{operation: op, frame_index: f[5:0], evictable_value: ev};
      t.fixed = fixed;
      t.want = '{evict_ok: ok, victim_frame: v[5:0], status: st,
                 evictable_count: cnt[6:0]};
      return t;
   endfunction

   // Random operation: mostly a small working set so frames build history,
   // get marked and compete in evict; sometimes any frame at all.
   function automatic lkr_pkg::req_type random_op();
      lkr_pkg::req_type r;
      int      pct;
      pct = $urandom_range(99);
      if (pct < 40)      r.operation = lkr_pkg::OP_ACCESS;
      else if (pct < 68) r.operation = lkr_pkg::OP_SET_EVICTABLE;
      else if (pct < 78) r.operation = lkr_pkg::OP_REMOVE;
      else               r.operation = lkr_pkg::OP_EVICT;
      r.frame_index = ($urandom_range(9) < 7) ? 6'($urandom_range(11)) : 6'($urandom);
      r.evictable_value = ($urandom_range(99) < 75);
      return r;
   endfunction

   // Receiver: stall at random, check every result taken.
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);

   always @(posedge clock) begin
      lkr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsps.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result %h", $time, rsp_payload);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_payload.evict_ok)      evict_hits++;
            if (rsp_payload.status)        refusals++;
            if (rsp_payload !== want) begin
               error_count++;
               $display("%0t: mismatch expected ok=%0d victim=%0d status=%0d count=%0d, %s",
                        $time, want.evict_ok, want.victim_frame, want.status,
                        want.evictable_count,
                        $sformatf("actual ok=%0d victim=%0d status=%0d count=%0d",
                                  rsp_payload.evict_ok, rsp_payload.victim_frame,
                                  rsp_payload.status, rsp_payload.evictable_count));
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("lru_k_frame_replacer_tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [3:0]       depth_plan [6];
      lkr_pkg::rsp_type none;
      none = '0;
      depth_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2};
      for (int i = 0; i < FRAMES; i++) begin
         use_count[i] = 0; ring_head[i] = 0; evict_mark[i] = 0;
         for (int j = 0; j < HIST_SLOTS; j++) stamp_ring[i][j] = '0;
      end
      mark_total = 0; stamp_clock = 0; depth_reg = lkr_pkg::HIST_DEPTH_RESET;

      // Directed table, K = 2 from reset.
      directed = {directed, row(lkr_pkg::OP_EVICT, 0, 0, 1, 0, 0, 0, 0)};
      directed = {directed, row(lkr_pkg::OP_SET_EVICTABLE, 5, 1, 1, 0, 0, 0, 0)};
      directed = {directed, row(lkr_pkg::OP_REMOVE, 5, 0, 1, 0, 0, 0, 0)};
      directed = {directed, row(lkr_pkg::OP_ACCESS, 0, 0)};
      directed = {directed, row(lkr_pkg::OP_ACCESS, 63, 1)};
      directed = {directed, row(lkr_pkg::OP_REMOVE, 0, 0, 1, 0, 0, 1, 0)};
      directed = {directed, row(lkr_pkg::OP_SET_EVICTABLE, 0, 1, 1, 0, 0, 0, 1)};
      directed = {directed, row(lkr_pkg::OP_SET_EVICTABLE, 63, 1, 1, 0, 0, 0, 2)};
      directed = {directed, row(lkr_pkg::OP_EVICT, 0, 0, 1, 1, 0, 0, 1)};
      directed = {directed, row(lkr_pkg::OP_ACCESS, 63, 0)};
      directed = {directed, row(lkr_pkg::OP_ACCESS, 42, 0)};
      directed = {directed, row(lkr_pkg::OP_ACCESS, 42, 1)};
      directed = {directed, row(lkr_pkg::OP_SET_EVICTABLE, 42, 1)};
      directed = {directed, row(lkr_pkg::OP_EVICT, 0, 0, 1, 1, 63, 0, 1)};
      directed = {directed, row(lkr_pkg::OP_SET_EVICTABLE, 42, 0, 1, 0, 0, 0, 0)};
      directed = {directed, row(lkr_pkg::OP_REMOVE, 42, 0, 1, 0, 0, 1, 0)};
      directed = {directed, row(lkr_pkg::OP_SET_EVICTABLE, 42, 1)};
      directed = {directed, row(lkr_pkg::OP_REMOVE, 42, 1, 1, 0, 0, 0, 0)};
      directed = {directed, row(lkr_pkg::OP_EVICT, 63, 1, 1, 0, 0, 0, 0)};
      directed = {directed, row(lkr_pkg::OP_ACCESS, 21, 1)};
      directed = {directed, row(lkr_pkg::OP_SET_EVICTABLE, 21, 1)};
      directed = {directed, row(lkr_pkg::OP_SET_EVICTABLE, 21, 1, 1, 0, 0, 0, 1)};
      directed = {directed, row(lkr_pkg::OP_EVICT, 0, 0, 1, 1, 21, 0, 0)};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) issue(directed[i].op, directed[i].fixed, directed[i].want);

      // Random phases: walk K through its extremes, shift the idle pattern.
      for (int p = 0; p < 6; p++) begin
         write_depth(depth_plan[p]);
         if (p < 2) begin
            sender_idle_pct = 12; receiver_idle_pct = 47;
         end else if (p < 4) begin
            sender_idle_pct = 47; receiver_idle_pct = 12;
         end else begin
            sender_idle_pct = 0; receiver_idle_pct = 0;
         end
         for (int n = 0; n < PHASE_OPS; n++) begin
            // Hold off once mid-phase until the block has nothing outstanding.
            if (p == 1 && n == PHASE_OPS / 2) drain();
            issue(random_op(), 0, none);
         end
      end

      drain();
      repeat (100) @(negedge clock);
      $display("Covered %0d results: %0d evictions, %0d refused removes, K in 0..15.",
               rsp_seen, evict_hits, refusals);
      if (error_count == 0) begin
         $display("lru_k_frame_replacer_tb: done, clean");
      end else begin
         $display("lru_k_frame_replacer_tb: done, errors");
      end
      $finish;
   end

endmodule
